### rtl/core/b64d_pkg.sv
// package: shared types, constants and the alphabet lookup for the base64 decoder
`timescale 1ns / 1ps

package b64d_pkg;

    // ascii codes of interest
    localparam logic [7:0] PAD_CODE     = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    // sextet offsets of the alphabet ranges
    localparam logic [5:0] LOWER_BASE = 6'd26;
    localparam logic [5:0] DIGIT_BASE = 6'd52;
    localparam logic [5:0] PLUS_VAL   = 6'd62;
    localparam logic [5:0] SLASH_VAL  = 6'd63;

    // position within a four-character group
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // queue between front and back end
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // classified character as it travels to the back end
    typedef struct packed {
        logic [5:0] sextet;
        logic       is_pad;
        logic       is_alpha;
        logic       last_char;
    } b64d_item_t;

    // map one character to its classified form
    function automatic b64d_item_t classify(input logic [7:0] code, input logic last);
        b64d_item_t item;
        item.sextet    = '0;
        item.is_pad    = (code == PAD_CODE);
        item.is_alpha  = 1'b1;
        item.last_char = last;
        if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z)
        begin
            item.sextet = 6'(code - CHAR_UPPER_A);
        end
        else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z)
        begin
            item.sextet = 6'(code - CHAR_LOWER_A) + LOWER_BASE;
        end
        else if (code >= CHAR_DIGIT_0 && code <= CHAR_DIGIT_9)
        begin
            item.sextet = 6'(code - CHAR_DIGIT_0) + DIGIT_BASE;
        end
        else if (code == CHAR_PLUS)
        begin
            item.sextet = PLUS_VAL;
        end
        else if (code == CHAR_SLASH)
        begin
            item.sextet = SLASH_VAL;
        end
        else
        begin
            item.is_alpha = 1'b0;
        end
        return item;
    endfunction

endpackage

### rtl/core/b64d_if.sv
// interfaces: character input channel and decoded byte output channel
`timescale 1ns / 1ps

interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       stream_end;
    logic       bad_char;

    modport source (output valid, output data_byte, output byte_valid,
                    output stream_end, output bad_char, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input stream_end, input bad_char, output ready);
endinterface

### rtl/core/b64d_front.sv
// front end: accepts characters, classifies them and registers the result
`timescale 1ns / 1ps

module b64d_front (
    input  logic                clk,
    input  logic                rst_n,
    b64d_char_if.sink           char_chan,
    output logic                item_valid,
    input  logic                item_ready,
    output b64d_pkg::b64d_item_t item
);
    import b64d_pkg::*;

    logic       vld_reg;
    b64d_item_t item_reg;
    logic       take;

    // accept a beat whenever the stage is empty or drains this cycle
    assign char_chan.ready = !vld_reg || item_ready;
    assign take            = char_chan.valid && char_chan.ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (take)
        begin
            vld_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    // classified payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= classify(char_chan.char_code, char_chan.last_char);
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

### rtl/core/b64d_fifo.sv
// short queue that decouples the front end from the decode back end
`timescale 1ns / 1ps

module b64d_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  b64d_pkg::b64d_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output b64d_pkg::b64d_item_t pop_item
);
    import b64d_pkg::*;

    b64d_item_t            mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    // pointer advance with wrap at the queue depth
    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/b64d_back.sv
// back end: group tracking, byte assembly and the output register
`timescale 1ns / 1ps

module b64d_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  b64d_pkg::b64d_item_t item,
    b64d_byte_if.source          byte_chan
);
    import b64d_pkg::*;

    // decode state
    logic [5:0] left_reg;
    logic [5:0] left_next;
    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic       pad_seen_reg;
    logic       pad_seen_next;

    // result register
    logic       out_vld_reg;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       bv_reg;
    logic       bv_next;
    logic       end_reg;
    logic       bad_reg;
    logic       bad_next;

    logic       take;

    assign item_ready = !out_vld_reg || byte_chan.ready;
    assign take       = item_valid && item_ready;

    // one decode step per character
    always_comb
    begin
        left_next     = left_reg;
        pos_next      = pos_reg;
        pad_seen_next = pad_seen_reg;
        byte_next     = '0;
        bv_next       = 1'b0;
        bad_next      = 1'b0;
        if (item.is_pad)
        begin
            if (pos_reg == POS_THIRD)
            begin
                pad_seen_next = 1'b1;
                pos_next      = POS_FOURTH;
            end
            else if (pos_reg == POS_FOURTH)
            begin
                pad_seen_next = 1'b0;
                pos_next      = POS_FIRST;
                left_next     = '0;
            end
            else
            begin
                bad_next = 1'b1;
            end
        end
        else if (!item.is_alpha || pad_seen_reg)
        begin
            bad_next = 1'b1;
        end
        else
        begin
            unique case (pos_reg)
                POS_FIRST:
                begin
                    left_next = item.sextet;
                end
                POS_SECOND:
                begin
                    byte_next = {left_reg, item.sextet[5:4]};
                    bv_next   = 1'b1;
                    left_next = {2'b00, item.sextet[3:0]};
                end
                POS_THIRD:
                begin
                    byte_next = {left_reg[3:0], item.sextet[5:2]};
                    bv_next   = 1'b1;
                    left_next = {4'b0000, item.sextet[1:0]};
                end
                default:
                begin
                    byte_next = {left_reg[1:0], item.sextet};
                    bv_next   = 1'b1;
                    left_next = '0;
                end
            endcase
            pos_next = pos_reg + 1'b1;
        end
        // final character closes the stream
        if (item.last_char)
        begin
            if (pos_next == POS_SECOND)
            begin
                bad_next = 1'b1;
            end
            left_next     = '0;
            pos_next      = POS_FIRST;
            pad_seen_next = 1'b0;
        end
    end

    // control state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= '0;
            pos_reg      <= POS_FIRST;
            pad_seen_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else if (take)
        begin
            left_reg     <= left_next;
            pos_reg      <= pos_next;
            pad_seen_reg <= pad_seen_next;
            out_vld_reg  <= 1'b1;
        end
        else if (byte_chan.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= byte_next;
            bv_reg   <= bv_next;
            end_reg  <= item.last_char;
            bad_reg  <= bad_next;
        end
    end

    assign byte_chan.valid      = out_vld_reg;
    assign byte_chan.data_byte  = byte_reg;
    assign byte_chan.byte_valid = bv_reg;
    assign byte_chan.stream_end = end_reg;
    assign byte_chan.bad_char   = bad_reg;

    // a completed byte is never flagged bad
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_chan.valid && byte_chan.byte_valid |-> !byte_chan.bad_char)
        else $error("byte beat carries bad_char");

    // padding can only be pending at the last group position
    assert property (@(posedge clk) disable iff (!rst_n)
        pad_seen_reg |-> pos_reg == POS_FOURTH)
        else $error("padding pending outside the last group position");

    // the final character returns the decoder to its idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        take && item.last_char |=> pos_reg == POS_FIRST && !pad_seen_reg && left_reg == '0)
        else $error("state not cleared after the final character");

    // every character taken shows up as a result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> byte_chan.valid)
        else $error("result beat missing after a character was taken");

endmodule

### rtl/core/base64_stream_decoder_unit.sv
// top level of the streaming base64 decoder
`timescale 1ns / 1ps

// Streaming base64 decoder for the standard alphabet: one character beat in, one result
// beat out. Sustained rate is one character per clock while dec_chan.ready is held high;
// the back end does one decode step per cycle and the output register reloads in the same
// cycle its beat is taken. While a result waits, the classify stage and the queue keep
// taking characters until three are held, then enc_chan.ready drops.
// An input beat reaches its result beat through the classify register, the queue and the
// result register. A byte is reported on the second, third and fourth character of a
// group; '=' padding is optional, and the beat marked last_char resets the group state.
// bad_char flags characters outside the alphabet, misplaced padding, data after padding,
// and a final group of one character; flagged characters are otherwise ignored.

module base64_stream_decoder_unit (
    input  logic         clk,
    input  logic         rst_n,
    b64d_char_if.sink    enc_chan,
    b64d_byte_if.source  dec_chan
);
    import b64d_pkg::*;

    logic       f_valid;
    logic       f_ready;
    b64d_item_t f_item;
    logic       q_valid;
    logic       q_ready;
    b64d_item_t q_item;

    // classify incoming characters
    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_chan  (enc_chan),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    // decoupling queue
    b64d_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // decode and deliver
    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .byte_chan  (dec_chan)
    );

endmodule

### tb/tb_base64_stream_decoder_unit.sv
// testbench: random and directed character streams checked against a base64 decode predictor
`timescale 1ns / 1ps

module tb_base64_stream_decoder_unit;
    import b64d_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int TAIL_ITEMS   = 200;
    localparam int MAX_SHOWN    = 10;

    // one decoded result beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       stream_end;
        logic       bad_char;
    } dec_result_t;

    // decode predictor and queue of results still owed by the block
    class decode_scoreboard;
        logic [5:0]  leftover;
        logic [1:0]  group_pos;
        logic        pad_seen;
        dec_result_t owed_q[$];
        int          mismatches;

        function new();
            leftover   = '0;
            group_pos  = POS_FIRST;
            pad_seen   = 1'b0;
            mismatches = 0;
        endfunction

        // 6-bit value of a character, bit 6 set when it is outside the alphabet
        function logic [6:0] sextet_value(input logic [7:0] code);
            logic [6:0] sx;
            sx = 7'd64;
            if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z)
            begin
                sx = 7'(code - CHAR_UPPER_A);
            end
            else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z)
            begin
                sx = 7'(code - CHAR_LOWER_A) + 7'd26;
            end
            else if (code >= CHAR_DIGIT_0 && code <= CHAR_DIGIT_9)
            begin
                sx = 7'(code - CHAR_DIGIT_0) + 7'd52;
            end
            else if (code == CHAR_PLUS)
            begin
                sx = 7'd62;
            end
            else if (code == CHAR_SLASH)
            begin
                sx = 7'd63;
            end
            return sx;
        endfunction

        // advance the predicted state by one accepted character
        function void note_char(input logic [7:0] code, input logic last);
            dec_result_t r;
            logic [6:0]  sx;
            sx           = sextet_value(code);
            r.data_byte  = 8'h00;
            r.byte_valid = 1'b0;
            r.stream_end = last;
            r.bad_char   = 1'b0;
            if (code == PAD_CODE)
            begin
                if (group_pos == POS_THIRD)
                begin
                    pad_seen  = 1'b1;
                    group_pos = POS_FOURTH;
                end
                else if (group_pos == POS_FOURTH)
                begin
                    pad_seen  = 1'b0;
                    group_pos = POS_FIRST;
                    leftover  = '0;
                end
                else
                begin
                    r.bad_char = 1'b1;
                end
            end
            else if (sx[6] || pad_seen)
            begin
                r.bad_char = 1'b1;
            end
            else
            begin
                case (group_pos)
                    POS_FIRST:
                    begin
                        leftover = sx[5:0];
                    end
                    POS_SECOND:
                    begin
                        r.data_byte  = {leftover[5:0], sx[5:4]};
                        r.byte_valid = 1'b1;
                        leftover     = {2'b00, sx[3:0]};
                    end
                    POS_THIRD:
                    begin
                        r.data_byte  = {leftover[3:0], sx[5:2]};
                        r.byte_valid = 1'b1;
                        leftover     = {4'b0000, sx[1:0]};
                    end
                    default:
                    begin
                        r.data_byte  = {leftover[1:0], sx[5:0]};
                        r.byte_valid = 1'b1;
                        leftover     = '0;
                    end
                endcase
                group_pos = group_pos + 2'd1;
            end
            // the last character closes the stream
            if (last)
            begin
                if (group_pos == POS_SECOND)
                begin
                    r.bad_char = 1'b1;
                end
                leftover  = '0;
                group_pos = POS_FIRST;
                pad_seen  = 1'b0;
            end
            owed_q.insert(owed_q.size(), r);
        endfunction

        // compare one result beat with the oldest owed result
        function void check_result(input dec_result_t got);
            dec_result_t want;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    $display("unexpected result: byte=%02h valid=%0b end=%0b bad=%0b",
                             got.data_byte, got.byte_valid, got.stream_end, got.bad_char);
                end
                return;
            end
            want = owed_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    $display("mismatch: want byte=%02h valid=%0b end=%0b bad=%0b",
                             want.data_byte, want.byte_valid, want.stream_end,
                             want.bad_char);
                    $display("          got  byte=%02h valid=%0b end=%0b bad=%0b",
                             got.data_byte, got.byte_valid, got.stream_end, got.bad_char);
                end
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;

    decode_scoreboard sb;

    b64d_char_if enc_if();
    b64d_byte_if dec_if();

    base64_stream_decoder_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .enc_chan (enc_if),
        .dec_chan (dec_if)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run limit
    initial
    begin
        #500000;
        $display("tb_base64_stream_decoder_unit: errors");
        $finish;
    end

    // beat monitor on both channels
    always @(posedge clk)
    begin
        dec_result_t got;
        if (rst_n)
        begin
            if (enc_if.valid && enc_if.ready)
            begin
                sb.note_char(enc_if.char_code, enc_if.last_char);
            end
            if (dec_if.valid && dec_if.ready)
            begin
                got.data_byte  = dec_if.data_byte;
                got.byte_valid = dec_if.byte_valid;
                got.stream_end = dec_if.stream_end;
                got.bad_char   = dec_if.bad_char;
                sb.check_result(got);
            end
        end
    end

    // receiver with random stall bursts
    initial
    begin
        dec_if.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                dec_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            dec_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // random character of the alphabet
    function automatic logic [7:0] pick_alpha();
        int k;
        k = $urandom_range(0, 63);
        if (k < 26)
        begin
            return CHAR_UPPER_A + 8'(k);
        end
        else if (k < 52)
        begin
            return CHAR_LOWER_A + 8'(k - 26);
        end
        else if (k < 62)
        begin
            return CHAR_DIGIT_0 + 8'(k - 52);
        end
        else if (k == 62)
        begin
            return CHAR_PLUS;
        end
        return CHAR_SLASH;
    endfunction

    // one character beat, with an optional sender gap ahead of it
    task automatic send_char(input logic [7:0] code, input logic last, input bit gappy);
        if (gappy && $urandom_range(0, 5) == 0)
        begin
            enc_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        enc_if.valid     <= 1'b1;
        enc_if.char_code <= code;
        enc_if.last_char <= last;
        do
        begin
            @(posedge clk);
        end
        while (!enc_if.ready);
    endtask

    // a text fragment, last flag on its final character if asked
    task automatic send_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], last_at_end && (i == s.len() - 1), 1'b1);
        end
    endtask

    // stimulus
    initial
    begin
        logic [7:0] msg[$];
        int         sent;
        int         n_groups;
        int         at;
        bit         gappy;
        bit         drained;

        sb = new();
        rst_n            = 1'b0;
        idle_on          = 1'b1;
        enc_if.valid     = 1'b0;
        enc_if.char_code = 8'h00;
        enc_if.last_char = 1'b0;
        sent             = 0;
        drained          = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // alphabet extremes
        send_text("/+9z", 1'b0);
        send_text("aA0Z", 1'b0);
        // characters outside the alphabet
        send_char(8'h2A, 1'b0, 1'b1);
        send_char(8'h00, 1'b0, 1'b1);
        send_char(8'hFF, 1'b0, 1'b1);
        // padding at the first and second position
        send_text("=", 1'b0);
        send_text("T=Q==", 1'b0);
        // data after padding
        send_text("TQ=A=", 1'b0);
        // final group of one character
        send_text("T", 1'b1);
        // padded final group
        send_text("TWE=", 1'b1);

        // random streams: mostly well-formed, some noise and broken tails
        while (sent < RANDOM_ITEMS)
        begin
            msg.delete();
            gappy    = idle_on && ($urandom_range(0, 2) != 0);
            n_groups = $urandom_range(0, 4);
            repeat (n_groups * 4) msg.insert(msg.size(), pick_alpha());
            case ($urandom_range(0, 5))
                0: ;
                1:
                begin
                    msg.insert(msg.size(), pick_alpha());
                end
                2:
                begin
                    repeat (2) msg.insert(msg.size(), pick_alpha());
                    repeat (2) msg.insert(msg.size(), PAD_CODE);
                    repeat ($urandom_range(0, 1) * 4) msg.insert(msg.size(), pick_alpha());
                end
                3:
                begin
                    repeat (2) msg.insert(msg.size(), pick_alpha());
                end
                4:
                begin
                    repeat (3) msg.insert(msg.size(), pick_alpha());
                    msg.insert(msg.size(), PAD_CODE);
                end
                default:
                begin
                    repeat (3) msg.insert(msg.size(), pick_alpha());
                end
            endcase
            if (msg.size() == 0)
            begin
                msg.insert(msg.size(), pick_alpha());
            end
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    at = $urandom_range(0, msg.size() - 1);
                    if ($urandom_range(0, 1) != 0)
                    begin
                        msg.insert(at, 8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        msg.insert(at, PAD_CODE);
                    end
                end
            end
            foreach (msg[i])
            begin
                send_char(msg[i], i == msg.size() - 1, gappy);
            end
            sent += msg.size();

            // hold off once until the block has delivered everything
            if (!drained && sent >= RANDOM_ITEMS / 2)
            begin
                enc_if.valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (sb.pending() != 0);
                drained = 1'b1;
            end
            if (sent >= RANDOM_ITEMS - TAIL_ITEMS)
            begin
                idle_on = 1'b0;
            end
        end

        // drain and finish
        enc_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("tb_base64_stream_decoder_unit: clean");
        end
        else
        begin
            $display("tb_base64_stream_decoder_unit: errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_if.sv
rtl/core/b64d_front.sv
rtl/core/b64d_fifo.sv
rtl/core/b64d_back.sv
rtl/core/base64_stream_decoder_unit.sv
tb/tb_base64_stream_decoder_unit.sv
